// File: sv/trigger_status_packet_framer_macros.svh
// Assertion macros for the trigger status packet framer.
`ifndef TRIGGER_STATUS_PACKET_FRAMER_MACROS_SVH
`define TRIGGER_STATUS_PACKET_FRAMER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define TSPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define TSPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tspf_pkg.sv
// Shared types and constants of the trigger status packet framer.
`default_nettype none

package tspf_pkg;

   localparam int PACKET_W = 40;
   localparam int STATUS_W = 8;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [7:0] HDR_STATUS   = 8'h33;
   localparam logic [7:0] HDR_RESPONSE = 8'hAA;

   localparam logic [1:0] MODE_SERIAL = 2'd1;
   localparam logic [1:0] MODE_ETHER  = 2'd2;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [1:0] REG_RUN_ENABLE    = 2'd0;
   localparam logic [1:0] REG_REMOTE_MODE   = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd10;

   typedef struct packed {
      logic        run_enable;
      logic [1:0]  remote_mode;
      logic [15:0] timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic                is_clear;
      logic                to_store;
      logic                to_remote;
      logic [STATUS_W-1:0] status_code;
      logic [PACKET_W-1:0] packet;
   } result_type;

endpackage

`default_nettype wire

// File: sv/trigger_status_packet_framer.sv
// Top level of the trigger status packet framer: request and result registers.
//
//   channel  direction  tdata                         tuser
//   req_     in         rx_byte[7:0]                  action[0]
//   rsp_     out        packet[39:0] status[47:40]    to_remote, to_store, is_clear
//   csr_     in         APB registers at 0x0, 0x4, 0x8
//
// One request per cycle while req_tready is high; rsp_tvalid rises when a result is emitted.
// The request register feeds the framer state update, which loads the result register.
// Reset is synchronous and clears the valid flags and framer state; no clearing pass.
// A stalled result holds the result register; one further request waits in the
// request register, and req_tready drops only when both are full and rsp_tready is low.
`default_nettype none

`include "trigger_status_packet_framer_macros.svh"

module trigger_status_packet_framer #(
   parameter int PACKET_BYTES = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   input  wire logic [0:0]  req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // packet, status_code
   output logic [2:0]       rsp_tuser,   // to_remote, to_store, is_clear
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [tspf_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [tspf_pkg::DATA_W-1:0] csr_pwdata,
   output logic [tspf_pkg::DATA_W-1:0]  csr_prdata,
   output logic             csr_pready
);
   import tspf_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       emit;
   logic       in_valid_ff, in_valid_in;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;
   logic       advance;

   tspf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tspf_core #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .action  (in_action_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .emit    (emit),
      .result  (result)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= req_tuser[0];
         in_byte_ff   <= req_tdata;
      end
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.status_code, rsp_data_ff.packet};
   assign rsp_tuser  = {rsp_data_ff.is_clear, rsp_data_ff.to_store, rsp_data_ff.to_remote};

   `TSPF_ASSERT_NOW(a_full_stall_blocks_req, clock, reset,
      in_valid_ff && rsp_tvalid && !rsp_tready, !req_tready, "request taken while full")
   `TSPF_ASSERT_NOW(a_clear_has_zero_status, clock, reset,
      rsp_tvalid && rsp_tuser[2], rsp_tdata[47:40] == 8'd0, "cleared status not zero")
   `TSPF_ASSERT_NOW(a_single_route, clock, reset,
      rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]), "both remote and store flagged")
   `TSPF_ASSERT_NEXT(a_emit_sets_valid, clock, reset,
      emit, rsp_tvalid, "result lost after emit")

endmodule

`default_nettype wire

// File: sv/tspf_csr.sv
// Configuration registers of the trigger status packet framer.
`default_nettype none

module tspf_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [tspf_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [tspf_pkg::DATA_W-1:0] csr_pwdata,
   output logic [tspf_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output tspf_pkg::cfg_type            cfg
);
   import tspf_pkg::*;

   logic        run_enable_ff,    run_enable_in;
   logic [1:0]  remote_mode_ff,   remote_mode_in;
   logic [15:0] timeout_limit_ff, timeout_limit_in;
   logic        write_en;
   logic [1:0]  reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      run_enable_in    = run_enable_ff;
      remote_mode_in   = remote_mode_ff;
      timeout_limit_in = timeout_limit_ff;
      if (write_en) begin
         case (reg_index)
            REG_RUN_ENABLE:    run_enable_in    = csr_pwdata[0];
            REG_REMOTE_MODE:   remote_mode_in   = csr_pwdata[1:0];
            REG_TIMEOUT_LIMIT: timeout_limit_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_RUN_ENABLE:    csr_prdata = DATA_W'(run_enable_ff);
         REG_REMOTE_MODE:   csr_prdata = DATA_W'(remote_mode_ff);
         REG_TIMEOUT_LIMIT: csr_prdata = DATA_W'(timeout_limit_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_enable_ff    <= 1'b0;
         remote_mode_ff   <= 2'd0;
         timeout_limit_ff <= TIMEOUT_RESET;
      end else begin
         run_enable_ff    <= run_enable_in;
         remote_mode_ff   <= remote_mode_in;
         timeout_limit_ff <= timeout_limit_in;
      end
   end

   assign cfg.run_enable    = run_enable_ff;
   assign cfg.remote_mode   = remote_mode_ff;
   assign cfg.timeout_limit = timeout_limit_ff;

endmodule

`default_nettype wire

// File: sv/tspf_core.sv
// Packet assembly, header check and timeout counter of the framer.
`default_nettype none

module tspf_core #(
   parameter int PACKET_BYTES = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                action,
   input  wire logic [7:0]          rx_byte,
   input  wire tspf_pkg::cfg_type   cfg,
   output logic                     emit,
   output tspf_pkg::result_type     result
);
   import tspf_pkg::*;

   localparam int COLL_W = 8 * PACKET_BYTES;
   localparam int POS_W  = $clog2(PACKET_BYTES);
   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(PACKET_BYTES - 1);
   localparam logic [COLL_W-1:0] CLEAR_PKT = {HDR_STATUS, {(COLL_W-8){1'b0}}};

   logic [POS_W-1:0]           pos_ff,   pos_in;
   logic [COLL_W-1:0]          coll_ff,  coll_in;
   logic [15:0]                timer_ff, timer_in;
   logic [COLL_W-1:0]          coll_upd;
   logic [COLL_W+PACKET_W-1:0] ext_upd;
   logic [COLL_W+PACKET_W-1:0] ext_clr;
   logic                       header_ok;
   logic                       remote_active;

   always_comb begin
      coll_upd = coll_ff;
      for (int i = 0; i < PACKET_BYTES; i++) begin
         if (pos_ff == POS_W'(i)) begin
            coll_upd[(PACKET_BYTES-1-i)*8 +: 8] = rx_byte;
         end
      end
   end

   assign ext_upd       = {{PACKET_W{1'b0}}, coll_upd};
   assign ext_clr       = {{PACKET_W{1'b0}}, CLEAR_PKT};
   assign header_ok     = (rx_byte == HDR_STATUS) || (rx_byte == HDR_RESPONSE);
   assign remote_active = (cfg.remote_mode == MODE_SERIAL) ||
                          (cfg.remote_mode == MODE_ETHER);

   always_comb begin
      pos_in           = pos_ff;
      coll_in          = coll_ff;
      timer_in         = timer_ff;
      emit             = 1'b0;
      result           = '0;
      result.to_remote = (cfg.remote_mode == MODE_SERIAL);
      result.to_store  = (cfg.remote_mode == MODE_ETHER);
      if (step && cfg.run_enable) begin
         unique case (action)
            ACTION_BYTE: begin
               if ((pos_ff != '0) || header_ok) begin
                  if (pos_ff == LAST_POS) begin
                     pos_in  = '0;
                     coll_in = '0;
                     if (coll_upd[COLL_W-1 -: 8] == HDR_STATUS) begin
                        emit               = 1'b1;
                        result.packet      = ext_upd[PACKET_W-1:0];
                        result.status_code = coll_upd[COLL_W-9 -: 8];
                        if (remote_active) begin
                           timer_in = 16'd1;
                        end
                     end
                  end else begin
                     pos_in  = pos_ff + 1'b1;
                     coll_in = coll_upd;
                  end
               end
            end
            ACTION_TICK: begin
               if (remote_active && (timer_ff != 16'd0)) begin
                  timer_in = timer_ff + 16'd1;
                  if (timer_ff > cfg.timeout_limit) begin
                     timer_in        = 16'd0;
                     coll_in         = CLEAR_PKT;
                     emit            = 1'b1;
                     result.packet   = ext_clr[PACKET_W-1:0];
                     result.is_clear = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         coll_ff  <= '0;
         timer_ff <= 16'd0;
      end else begin
         pos_ff   <= pos_in;
         coll_ff  <= coll_in;
         timer_ff <= timer_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/trigger_status_packet_framer_test.sv
// Self-checking testbench of the trigger status packet framer: streamed bytes and ticks.
`timescale 1ns / 100ps

module trigger_status_packet_framer_test;
   import tspf_pkg::*;

   localparam int FRAME_BYTES  = 5;
   localparam int SETTLE       = 8;
   localparam int LIMIT_CYCLES = 4000000;

   typedef struct packed {
      logic       action;
      logic [7:0] rx;
   } request_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // rx_byte
   logic [0:0]  req_tuser = '0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // packet, status_code
   logic [2:0]  rsp_tuser;        // to_remote, to_store, is_clear
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   request_item_type rx_queue[$];
   result_type  status_packets_due[$];
   int          rx_outstanding = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          pat_age = 0;
   logic [7:0]  stall_pat = 8'hFF;

   cfg_type     framer_cfg;
   int          frame_pos = 0;
   logic [39:0] frame_bytes = '0;
   logic [15:0] status_timer = '0;

   trigger_status_packet_framer uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic remote_on();
      return framer_cfg.remote_mode == MODE_SERIAL || framer_cfg.remote_mode == MODE_ETHER;
   endfunction

   function automatic bit advance_framer(logic action, logic [7:0] rx, output result_type res);
      int          sh;
      logic [15:0] prior;
      logic [39:0] pkt;
      res = '0;
      res.to_remote = framer_cfg.remote_mode == MODE_SERIAL;
      res.to_store  = framer_cfg.remote_mode == MODE_ETHER;
      if (!framer_cfg.run_enable)
         return 0;
      if (action == ACTION_BYTE) begin
         if (frame_pos == 0 && rx != HDR_STATUS && rx != HDR_RESPONSE)
            return 0;
         if (frame_pos >= FRAME_BYTES)
            frame_pos = 0;
         sh = (FRAME_BYTES - 1 - frame_pos) * 8;
         frame_bytes[sh +: 8] = rx;
         frame_pos++;
         if (frame_pos < FRAME_BYTES)
            return 0;
         pkt = frame_bytes;
         frame_pos = 0;
         frame_bytes = '0;
         if (pkt[39:32] != HDR_STATUS)
            return 0;
         if (remote_on())
            status_timer = 16'd1;
         res.packet = pkt;
         res.status_code = pkt[31:24];
         return 1;
      end
      if (!remote_on() || status_timer == 0)
         return 0;
      prior = status_timer;
      status_timer = status_timer + 16'd1;
      if (prior > framer_cfg.timeout_limit) begin
         status_timer = '0;
         frame_bytes = {HDR_STATUS, 32'h0};
         res.packet = frame_bytes;
         res.is_clear = 1'b1;
         return 1;
      end
      return 0;
   endfunction

   task automatic check_field(string name, logic [39:0] want, logic [39:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // drive requests in bursts
   always @(posedge clock) begin
      request_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0 || rx_queue.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            nxt = rx_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= nxt.rx;
            req_tuser <= nxt.action;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // stall the result channel on a rotating pattern
   always @(posedge clock) begin
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      if (pat_age == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pat = 8'hFF;
            1: stall_pat = 8'h0F;
            default: stall_pat = 8'($urandom) | 8'h01;
         endcase
         pat_age = $urandom_range(16, 96);
      end else begin
         pat_age--;
      end
      rsp_tready <= stall_pat[0];
   end

   always @(posedge clock) begin
      result_type res;
      if (!reset && req_tvalid && req_tready) begin
         rx_outstanding--;
         if (advance_framer(req_tuser[0], req_tdata, res))
            status_packets_due.push_back(res);
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'({rsp_tuser, rsp_tdata});
         if (status_packets_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = status_packets_due.pop_front();
            check_field("packet", want.packet, got.packet);
            check_field("status_code", 40'(want.status_code), 40'(got.status_code));
            check_field("to_remote", 40'(want.to_remote), 40'(got.to_remote));
            check_field("to_store", 40'(want.to_store), 40'(got.to_store));
            check_field("is_clear", 40'(want.is_clear), 40'(got.is_clear));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_RUN_ENABLE:    framer_cfg.run_enable = value[0];
         REG_REMOTE_MODE:   framer_cfg.remote_mode = value[1:0];
         REG_TIMEOUT_LIMIT: framer_cfg.timeout_limit = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_framer(logic enable, logic [1:0] mode, logic [15:0] limit);
      csr_write(REG_RUN_ENABLE, {31'b0, enable});
      csr_write(REG_REMOTE_MODE, {30'b0, mode});
      csr_write(REG_TIMEOUT_LIMIT, {16'b0, limit});
   endtask

   task automatic wait_framer_idle();
      while (rx_outstanding != 0 || status_packets_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_byte(logic [7:0] b);
      rx_queue.push_back({ACTION_BYTE, b});
      rx_outstanding++;
   endtask

   task automatic push_ticks(int count);
      repeat (count) begin
         rx_queue.push_back({ACTION_TICK, 8'($urandom)});
         rx_outstanding++;
      end
   endtask

   task automatic push_frame(logic [7:0] hdr, logic [7:0] status, logic [23:0] tail);
      push_byte(hdr);
      push_byte(status);
      push_byte(tail[23:16]);
      push_byte(tail[15:8]);
      push_byte(tail[7:0]);
   endtask

   // mostly whole frames, some ticks, some noise and cut frames
   task automatic push_random_chunk(inout int added);
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            push_frame(HDR_STATUS, 8'($urandom), 24'($urandom));
            added += FRAME_BYTES;
         end
         5, 6: begin
            push_frame(HDR_RESPONSE, 8'($urandom), 24'($urandom));
            added += FRAME_BYTES;
         end
         7, 8: begin
            n = $urandom_range(1, (framer_cfg.timeout_limit > 30) ? 33 :
                                  framer_cfg.timeout_limit + 3);
            push_ticks(n);
            added += n;
         end
         default: begin
            n = $urandom_range(1, 3);
            repeat (n) push_byte(($urandom_range(0, 1) == 0) ? HDR_STATUS : 8'($urandom));
            added += n;
         end
      endcase
   endtask

   initial begin
      int added;
      int limit_pick;
      framer_cfg = {1'b0, 2'b00, TIMEOUT_RESET};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: drop everything
      push_frame(HDR_STATUS, 8'h5A, 24'h123456);
      push_ticks(1);
      wait_framer_idle();

      set_framer(1'b1, 2'd0, 16'd10);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_frame(HDR_STATUS, 8'hFF, 24'hFFFFFF);
      push_frame(HDR_RESPONSE, 8'h01, 24'h000000);
      push_ticks(2);
      wait_framer_idle();

      // clear at once, then clear a partial frame
      set_framer(1'b1, MODE_SERIAL, 16'd0);
      push_frame(HDR_STATUS, 8'h00, 24'h000000);
      push_ticks(2);
      push_frame(HDR_STATUS, 8'h80, 24'hA5A5A5);
      push_byte(HDR_RESPONSE);
      push_byte(8'h01);
      push_ticks(1);
      push_byte(8'h11);
      push_byte(8'h22);
      push_byte(8'h44);
      wait_framer_idle();

      // hold a partial frame across a disable
      set_framer(1'b1, MODE_ETHER, 16'd2);
      push_byte(HDR_STATUS);
      push_byte(8'h80);
      wait_framer_idle();
      set_framer(1'b0, MODE_ETHER, 16'd2);
      push_byte(8'h99);
      push_ticks(1);
      wait_framer_idle();
      set_framer(1'b1, MODE_ETHER, 16'd2);
      push_byte(8'h01);
      push_byte(8'h02);
      push_byte(8'h03);
      push_ticks(4);
      wait_framer_idle();

      // unused mode value
      set_framer(1'b1, 2'd3, 16'd0);
      push_frame(HDR_STATUS, 8'h7E, 24'h00FF00);
      push_ticks(3);
      wait_framer_idle();

      for (int phase = 0; phase < 4; phase++) begin
         limit_pick = $urandom_range(0, 3);
         set_framer(1'b1, 2'($urandom_range(0, 3)),
                    (limit_pick == 0) ? 16'd0 : (limit_pick == 1) ? 16'd1 :
                    (limit_pick == 2) ? 16'($urandom_range(2, 12)) : 16'd30);
         added = 0;
         while (added < 70)
            push_random_chunk(added);
         wait_framer_idle();
      end

      // hold the armed counter under a large limit
      set_framer(1'b1, MODE_SERIAL, 16'hFFFE);
      push_frame(HDR_STATUS, 8'h42, 24'h010203);
      push_ticks(12);
      wait_framer_idle();

      // hold the counter under the largest limit, then clear it
      set_framer(1'b1, MODE_ETHER, 16'hFFFF);
      push_frame(HDR_STATUS, 8'h24, 24'h030201);
      push_ticks(12);
      wait_framer_idle();
      set_framer(1'b1, MODE_ETHER, 16'd0);
      push_ticks(3);
      wait_framer_idle();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: trigger_status_packet_framer.f
+incdir+sv
sv/tspf_pkg.sv
sv/tspf_csr.sv
sv/tspf_core.sv
sv/trigger_status_packet_framer.sv
tb/trigger_status_packet_framer_test.sv
